// File: design/pcd_pkg.sv
// shared types and constants of the prefix code decoder
`timescale 1ns / 1ps

package pcd_pkg;

	localparam int NUM_SYMBOLS_DEF  = 95;
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int CHAR_BASE        = 32;

	localparam int IDX_W  = 7;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int CHAR_W = 7;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 8;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] pattern;
	} pcd_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} pcd_state_t;

endpackage

// File: design/pcd_table.sv
// code table memory with per-entry valid bits and a registered read port
`timescale 1ns / 1ps

module pcd_table #(
	parameter int NUM_SYMBOLS = pcd_pkg::NUM_SYMBOLS_DEF,
	parameter int AW          = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  pcd_pkg::pcd_entry_t wr_entry,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output pcd_pkg::pcd_entry_t rd_entry
);
	import pcd_pkg::*;

	pcd_entry_t             mem [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0] valid_q;
	pcd_entry_t             rd_data_s1;
	logic                   rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// an entry never written reads as length zero, i.e. no code
	always_comb begin
		rd_entry.pattern = rd_data_s1.pattern;
		rd_entry.len     = rd_vld_s1 ? rd_data_s1.len : '0;
	end

endmodule

// File: design/pcd_match.sv
// shared comparator: one table entry against the pending code
`timescale 1ns / 1ps

module pcd_match #(
	parameter int MAX_CODE_LEN = pcd_pkg::MAX_CODE_LEN_DEF,
	parameter int CNTW         = 6
) (
	input  pcd_pkg::pcd_entry_t entry,
	input  logic [MAX_CODE_LEN-1:0] pend_code,
	input  logic [CNTW-1:0]         pend_cnt,
	output logic                    match
);
	import pcd_pkg::*;

	logic [63:0] mask;
	logic [63:0] pat_w;
	logic [63:0] pend_w;
	logic        len_eq;

	always_comb begin
		mask   = ~(64'hFFFF_FFFF_FFFF_FFFF << entry.len);
		pat_w  = 64'(entry.pattern) & mask;
		pend_w = 64'(pend_code);
		len_eq = (8'(entry.len) == 8'(pend_cnt));
		match  = (entry.len != '0) && len_eq && (pat_w == pend_w);
	end

endmodule

// File: design/prefix_code_decoder_core.sv
// top level of the prefix code decoder: sequencer, pending code and output register
`timescale 1ns / 1ps

//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata (index, code, length, bit), s_tuser (action)
//  m_*     | out | m_tvalid/m_tready  | m_tdata (character), m_tuser (no match flag)
//
//  a load item writes one table entry, and the input stays ready for the next item
//  a decode item holds the input off while the entries are scanned, up to a hit;
//  the table memory has one read port and the comparator checks one entry a cycle
//  reset clears the valid bits of all entries at once, so no clearing pass
//  a result waits in the output register; new items are taken meanwhile, and a
//  further result waits in the sequencer until the output register frees

module prefix_code_decoder_core #(
	parameter int NUM_SYMBOLS  = pcd_pkg::NUM_SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = pcd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_index[6:0], entry_code[38:7], entry_length[44:39], bit_in[45], zero pad
	input  logic [pcd_pkg::S_DATA_W-1:0]  s_tdata,
	// action
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// char_out[6:0], zero pad
	output logic [pcd_pkg::M_DATA_W-1:0]  m_tdata,
	// no_match
	output logic                          m_tuser
);
	import pcd_pkg::*;

	localparam int AW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int CNTW = $clog2(MAX_CODE_LEN + 1);
	localparam logic [AW-1:0]   LAST_ADDR = AW'(NUM_SYMBOLS - 1);
	localparam logic [CNTW-1:0] MAX_CNT   = CNTW'(MAX_CODE_LEN);

	// input fields
	logic [IDX_W-1:0]  in_index;
	logic [CODE_W-1:0] in_code;
	logic [LEN_W-1:0]  in_len;
	logic              in_bit;

	assign in_index = s_tdata[6:0];
	assign in_code  = s_tdata[38:7];
	assign in_len   = s_tdata[44:39];
	assign in_bit   = s_tdata[45];

	pcd_state_t state_q, state_d;

	logic                    accept;
	logic                    load_acc;
	logic                    dec_acc;
	logic                    in_range;

	// pending code
	logic [MAX_CODE_LEN-1:0] pend_code_q;
	logic [CNTW-1:0]         pend_cnt_q;

	// scan sequencer
	logic [AW-1:0]           addr_q;
	logic                    done_issue_q;
	logic                    rd_en;
	logic                    cmp_vld_s1;
	logic [AW-1:0]           idx_s1;

	pcd_entry_t              wr_entry;
	pcd_entry_t              rd_entry;
	logic                    match;

	logic                    scan_hit;
	logic                    scan_end;
	logic                    scan_fail;
	logic                    out_free;
	logic [8:0]              char_sum;

	// held result and output register
	logic [CHAR_W-1:0]       res_char_q;
	logic                    res_nm_q;
	logic                    m_valid_q;
	logic [CHAR_W-1:0]       m_char_q;
	logic                    m_nm_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_range = (9'(in_index) < 9'(NUM_SYMBOLS));
	assign load_acc = accept && (s_tuser == ACT_LOAD);
	assign dec_acc  = accept && (s_tuser == ACT_DECODE);

	assign wr_entry.len     = in_len;
	assign wr_entry.pattern = in_code;

	// one read a cycle until the last entry has been issued
	assign rd_en = (state_q == ST_SCAN) && !done_issue_q;

	pcd_table #(
		.NUM_SYMBOLS (NUM_SYMBOLS),
		.AW          (AW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (load_acc && in_range),
		.wr_addr  (AW'(in_index)),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (addr_q),
		.rd_entry (rd_entry)
	);

	pcd_match #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.CNTW         (CNTW)
	) u_match (
		.entry     (rd_entry),
		.pend_code (pend_code_q),
		.pend_cnt  (pend_cnt_q),
		.match     (match)
	);

	// first hit in index order wins; the scan ends after the last entry
	assign scan_hit  = (state_q == ST_SCAN) && cmp_vld_s1 && match;
	assign scan_end  = (state_q == ST_SCAN) && cmp_vld_s1 && !match && (idx_s1 == LAST_ADDR);
	assign scan_fail = scan_end && (pend_cnt_q >= MAX_CNT);
	assign out_free  = !m_valid_q || m_tready;
	assign char_sum  = 9'(idx_s1) + 9'(CHAR_BASE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (dec_acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_hit || scan_fail) begin
					state_d = ST_EMIT;
				end else if (scan_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// pending code: shift in on an accepted decode item, clear on any result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_code_q <= '0;
			pend_cnt_q  <= '0;
		end else if (dec_acc) begin
			pend_code_q <= MAX_CODE_LEN'({pend_code_q, in_bit});
			if (pend_cnt_q < MAX_CNT) begin
				pend_cnt_q <= pend_cnt_q + CNTW'(1);
			end
		end else if (scan_hit || scan_fail) begin
			pend_code_q <= '0;
			pend_cnt_q  <= '0;
		end
	end

	// address counter and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			done_issue_q <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			idx_s1       <= '0;
		end else begin
			cmp_vld_s1 <= rd_en;
			idx_s1     <= addr_q;
			if (dec_acc) begin
				addr_q       <= '0;
				done_issue_q <= 1'b0;
			end else if (rd_en) begin
				if (addr_q == LAST_ADDR) begin
					done_issue_q <= 1'b1;
				end else begin
					addr_q <= addr_q + AW'(1);
				end
			end
		end
	end

	// result held until the output register is free
	always_ff @(posedge clk) begin
		if (scan_hit) begin
			res_char_q <= char_sum[CHAR_W-1:0];
			res_nm_q   <= 1'b0;
		end else if (scan_fail) begin
			res_char_q <= '0;
			res_nm_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			m_char_q <= res_char_q;
			m_nm_q   <= res_nm_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_char_q};
	assign m_tuser  = m_nm_q;

	// no-match results carry a zero character
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == '0))
		else $error("no-match result with nonzero character");

	// pending bit count stays within the code length limit
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= MAX_CNT)
		else $error("pending count beyond maximum code length");

	// a decode item starts a scan from the first entry
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_acc |=> (state_q == ST_SCAN) && (addr_q == '0) && !s_tready)
		else $error("decode item did not start a scan");

	// a hit clears the pending code and moves on to delivery
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_hit |=> (state_q == ST_EMIT) && (pend_cnt_q == '0))
		else $error("hit did not clear the pending code");

endmodule

// File: tb/prefix_code_decoder_core_tb.sv
// self-checking testbench of the prefix code decoder core
`timescale 1ns / 1ps

module prefix_code_decoder_core_tb;
	import pcd_pkg::*;

	localparam int NUM_SYM      = NUM_SYMBOLS_DEF;
	localparam int MAX_LEN      = MAX_CODE_LEN_DEF;
	localparam int RAND_ITEMS   = 800;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 120;
	localparam int NUM_ROWS     = 20;

	typedef struct packed {
		logic              nm;
		logic [CHAR_W-1:0] ch;
	} decoded_t;

	typedef struct packed {
		logic              act;
		logic [IDX_W-1:0]  idx;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic              din;
	} item_t;

	// where the expectation of a directed row comes from
	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_RESULT,
		EXP_NONE
	} exp_src_t;

	typedef struct {
		int       rep;
		item_t    it;
		exp_src_t src;
		decoded_t want;
	} row_t;

	localparam decoded_t NO_RES = '0;
	localparam decoded_t MISS   = '{nm: 1'b1, ch: '0};

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	// predictor state: code table and the partial code being gathered
	logic [CODE_W-1:0] tbl_pattern [NUM_SYM];
	logic [LEN_W-1:0]  tbl_len [NUM_SYM];
	logic [CODE_W-1:0] shift_code;
	int unsigned       shift_count;

	decoded_t due_chars [$];
	decoded_t want;
	int       mismatches = 0;
	int       rand_count = 0;
	int       ready_hold = 0;
	int       idle_cycles = 0;
	bit       steady = 1'b0;
	row_t     rows [NUM_ROWS];

	prefix_code_decoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [CODE_W-1:0] low_bits(input int n);
		return (n >= CODE_W) ? '1 : ((CODE_W'(1) << n) - CODE_W'(1));
	endfunction

	function automatic decoded_t hit(input int slot);
		return '{nm: 1'b0, ch: CHAR_W'(slot + CHAR_BASE)};
	endfunction

	// unused fields carry random values, the block must ignore them
	function automatic item_t load_item(input int slot, input logic [CODE_W-1:0] code,
	                                    input int len);
		return '{act: ACT_LOAD, idx: IDX_W'(slot), code: code, len: LEN_W'(len),
		         din: 1'($urandom_range(0, 1))};
	endfunction

	function automatic item_t decode_item(input logic b);
		return '{act: ACT_DECODE, idx: IDX_W'($urandom_range(0, 127)), code: $urandom,
		         len: LEN_W'($urandom_range(0, 63)), din: b};
	endfunction

	// advances the predictor by one item, returns 1 when a character or miss comes out
	function automatic bit decode_step(input item_t it, output decoded_t res);
		res = NO_RES;
		if (it.act == ACT_LOAD) begin
			if (it.idx < NUM_SYM) begin
				tbl_pattern[it.idx] = it.code;
				tbl_len[it.idx]     = it.len;
			end
			return 1'b0;
		end
		shift_code = {shift_code[CODE_W-2:0], it.din};
		if (shift_count < MAX_LEN)
			shift_count++;
		// lowest slot wins when two entries hold the same code
		for (int n = 0; n < NUM_SYM; n++) begin
			if (tbl_len[n] != 0 && tbl_len[n] == shift_count &&
			    (tbl_pattern[n] & low_bits(tbl_len[n])) == shift_code) begin
				res = hit(n);
				shift_code  = '0;
				shift_count = 0;
				return 1'b1;
			end
		end
		if (shift_count >= MAX_LEN) begin
			res = MISS;
			shift_code  = '0;
			shift_count = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_item(input item_t it, input exp_src_t src, input decoded_t typed);
		decoded_t res;
		bit       emits;
		int       gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= it.act;
		s_tdata  <= {2'b00, it.din, it.len, it.code, it.idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		emits = decode_step(it, res);
		if (src == EXP_MODEL && emits)
			due_chars.push_back(res);
		else if (src == EXP_RESULT)
			due_chars.push_back(typed);
	endtask

	task automatic issue(input item_t it);
		send_item(it, EXP_MODEL, NO_RES);
		// loads to slots outside the table are ignored and do not count
		if (it.act == ACT_DECODE || it.idx < NUM_SYM)
			rand_count++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_chars.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [CODE_W-1:0] leaf_pat [$];
		int                leaf_len [$];
		int                used_slots [$];
		int                perm [NUM_SYM];
		int                nleaves, drop, nsyms, j, k, tmp;
		bit                deep;
		exp_src_t          src_now;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_LOAD;
		for (int i = 0; i < NUM_SYM; i++) begin
			tbl_pattern[i] = '0;
			tbl_len[i]     = '0;
		end
		shift_code  = '0;
		shift_count = 0;

		rows = '{
			'{1,  load_item(0, 32'h0000_0000, 1),   EXP_NONE,   NO_RES},  // space is "0"
			'{1,  load_item(94, 32'hFFFF_FFFE, 32), EXP_NONE,   NO_RES},  // full length, last slot
			'{1,  load_item(1, 32'hFFFF_FFFE, 2),   EXP_NONE,   NO_RES},  // "10", junk above
			'{1,  decode_item(1'b0),                EXP_RESULT, hit(0)},
			'{1,  decode_item(1'b1),                EXP_MODEL,  NO_RES},
			'{1,  decode_item(1'b0),                EXP_RESULT, hit(1)},
			'{32, decode_item(1'b1),                EXP_RESULT, MISS},    // 32 ones match nothing
			'{1,  load_item(95, 32'h0000_0001, 1),  EXP_NONE,   NO_RES},  // just past the table
			'{1,  load_item(127, 32'hFFFF_FFFF, 63), EXP_NONE,  NO_RES},
			'{1,  decode_item(1'b1),                EXP_MODEL,  NO_RES},
			'{1,  decode_item(1'b0),                EXP_RESULT, hit(1)},
			'{1,  load_item(2, 32'h0000_0003, 40),  EXP_NONE,   NO_RES},  // too long, never hits
			'{1,  load_item(3, 32'h0000_0002, 2),   EXP_NONE,   NO_RES},  // same code as slot 1
			'{1,  load_item(4, 32'hFFFF_FFFF, 63),  EXP_NONE,   NO_RES},
			'{1,  decode_item(1'b1),                EXP_MODEL,  NO_RES},
			'{1,  decode_item(1'b0),                EXP_RESULT, hit(1)},  // lower slot wins
			'{1,  load_item(0, 32'h0000_0000, 0),   EXP_NONE,   NO_RES},  // slot 0 unused now
			'{1,  decode_item(1'b0),                EXP_MODEL,  NO_RES},
			'{1,  load_item(5, 32'h0000_0000, 2),   EXP_NONE,   NO_RES},  // load mid-code
			'{1,  decode_item(1'b0),                EXP_RESULT, hit(5)}
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_ROWS; i++) begin
			for (int r = 0; r < rows[i].rep; r++) begin
				src_now = (r == rows[i].rep - 1 || rows[i].src == EXP_MODEL) ?
				          rows[i].src : EXP_NONE;
				send_item(rows[i].it, src_now, rows[i].want);
			end
		end
		wait_drained();

		// random tables of prefix codes, each followed by a stream of encoded symbols
		while (rand_count < RAND_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			deep   = ($urandom_range(0, 3) == 0);
			nleaves = deep ? MAX_LEN + 1 : $urandom_range(2, 24);

			// grow a complete code tree by splitting leaves, deep trees form a chain
			leaf_pat = '{CODE_W'(0)};
			leaf_len = '{0};
			while (leaf_pat.size() < nleaves) begin
				j = deep ? leaf_pat.size() - 1 : $urandom_range(0, leaf_pat.size() - 1);
				if (leaf_len[j] < MAX_LEN) begin
					leaf_pat.push_back({leaf_pat[j][CODE_W-2:0], 1'b1});
					leaf_len.push_back(leaf_len[j] + 1);
					leaf_pat[j] = {leaf_pat[j][CODE_W-2:0], 1'b0};
					leaf_len[j] = leaf_len[j] + 1;
				end
			end

			// retire the previous table
			foreach (used_slots[u])
				issue(load_item(used_slots[u], $urandom, 0));
			used_slots.delete();

			for (int i = 0; i < NUM_SYM; i++)
				perm[i] = i;
			for (int i = NUM_SYM - 1; i > 0; i--) begin
				k = $urandom_range(0, i);
				tmp = perm[i];
				perm[i] = perm[k];
				perm[k] = tmp;
			end

			// sometimes one leaf stays unloaded so its bits run into a miss
			drop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, nleaves - 1) : -1;
			for (int i = 0; i < nleaves; i++) begin
				if (i != drop) begin
					issue(load_item(perm[i],
					                leaf_pat[i] | ($urandom & ~low_bits(leaf_len[i])),
					                leaf_len[i]));
					used_slots.push_back(perm[i]);
				end
			end

			nsyms = $urandom_range(8, 40);
			repeat (nsyms) begin
				j = $urandom_range(0, nleaves - 1);
				for (int b = leaf_len[j] - 1; b >= 0; b--)
					issue(decode_item(leaf_pat[j][b]));
			end

			// noise: stray bits or broken entries
			case ($urandom_range(0, 3))
				0: begin
					repeat ($urandom_range(1, 40))
						issue(decode_item(1'($urandom_range(0, 1))));
				end
				1: begin
					repeat ($urandom_range(1, 3)) begin
						k = $urandom_range(0, 127);
						issue(load_item(k, $urandom, $urandom_range(0, 63)));
						if (k < NUM_SYM)
							used_slots.push_back(k);
					end
				end
				default: ;
			endcase

			if ($urandom_range(0, 4) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// receiver back-pressure, one random hold per item
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n || ready_hold > 0) begin
				m_tready <= 1'b0;
				if (arst_n)
					ready_hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_chars.size() == 0) begin
				$error("unexpected item: char_out=%0d no_match=%0b", m_tdata[CHAR_W-1:0], m_tuser);
				mismatches++;
			end else begin
				want = due_chars.pop_front();
				if (m_tdata[CHAR_W-1:0] !== want.ch) begin
					$error("char_out: expected %0d, got %0d", want.ch, m_tdata[CHAR_W-1:0]);
					mismatches++;
				end
				if (m_tuser !== want.nm) begin
					$error("no_match: expected %0b, got %0b", want.nm, m_tuser);
					mismatches++;
				end
			end
			ready_hold = steady ? 0 : $urandom_range(0, 6);
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule
